[sv/gls_pkg.sv]
// ----------------------------------------------------------------------------
// gls_pkg: shared types for the growable list store
// Command and status codes, plus the read-out length limit.
// ----------------------------------------------------------------------------
package gls_pkg;

  // Command codes carried on cmd
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_GET    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REGION = 2'd1,
    ST_CLASS  = 2'd2
  } status_t;

  // Longest read out, in words
  localparam int MAX_OUT = 64;

endpackage

[sv/growable_list_store_unit.sv]
// ----------------------------------------------------------------------------
// growable_list_store_unit: append-only lists in power-of-two size classes
// Flow: start and in-place append give their one result from the decode
// state; a promoting append copies the full slot one word per cycle through the
// store's read/write ports, then writes the new value; a get of n words
// streams one word a cycle once its first read lands.
// The receiver cannot stall; a new command is taken as the last result shows.
// Reset clears the per-class fill pointers; the element store is not cleared.
// ----------------------------------------------------------------------------
module growable_list_store_unit #(
  parameter int NUM_CLASSES     = 7,
  parameter int WORDS_PER_CLASS = 1024,
  parameter int VALUE_WIDTH     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [2:0]  list_class,
  input  logic [10:0] list_end,
  input  logic [31:0] element_value,
  output logic        valid,
  output logic [2:0]  new_class,
  output logic [10:0] new_end,
  output logic [31:0] read_value,
  output logic        last,
  output logic [1:0]  status
);
  import gls_pkg::*;

  localparam int DEPTH = NUM_CLASSES * WORDS_PER_CLASS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(WORDS_PER_CLASS + 1);
  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int WX    = 22;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_COPY,
    S_READ
  } state_t;

  state_t state;

  // Latched command
  cmd_t                   c_cmd;
  logic [2:0]             c_cls;
  logic [10:0]            c_end;
  logic [VALUE_WIDTH-1:0] c_val;

  // Fill pointers, one per class
  logic [PW-1:0] fp [NUM_CLASSES];

  // Sequencer registers for copy and read out
  logic [AW-1:0] src_addr;
  logic [AW-1:0] dst_addr;
  logic [PW-1:0] cnt;
  logic          pend;
  logic [CW-1:0] up_idx;
  logic [PW-1:0] up_fp;
  logic [2:0]    up_class;
  logic [10:0]   up_end;
  logic          rv_sel;

  // Element store
  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;

  // Value width conversion
  logic [VALUE_WIDTH+31:0] in_ext;
  logic [VALUE_WIDTH+31:0] rd_ext;

  assign in_ext     = {{VALUE_WIDTH{1'b0}}, element_value};
  assign rd_ext     = {32'b0, rd_q};
  assign read_value = rv_sel ? rd_ext[31:0] : 32'b0;
  assign busy       = (state != S_IDLE);

  // ---------------------------------------------------------------------------
  // Decode of the latched command
  // ---------------------------------------------------------------------------
  logic [4:0]    cls5;
  logic [4:0]    cls_inc;
  logic          cls_ok;
  logic          dst_ok;
  logic [CW-1:0] src_idx;
  logic [CW-1:0] dst_idx;
  logic [AW-1:0] src_base;
  logic [AW-1:0] dst_base;
  logic [WX-1:0] end_x;
  logic [WX-1:0] len_x;
  logic [WX-1:0] wpc_x;
  logic [WX-1:0] f0_x;
  logic [WX-1:0] fn_x;
  logic [WX-1:0] beg_x;
  logic [WX-1:0] span_x;

  logic          dec_result;
  logic [2:0]    dec_class;
  logic [10:0]   dec_end;
  status_t       dec_status;
  logic          dec_we;
  logic [AW-1:0] dec_waddr;
  logic          dec_fp0_inc;
  logic          dec_copy;
  logic          dec_read;
  logic [AW-1:0] dec_src;
  logic [AW-1:0] dec_dst;
  logic [PW-1:0] dec_cnt;

  assign cls5     = {2'b00, c_cls};
  assign cls_inc  = cls5 + 5'd1;
  assign cls_ok   = (cls5 < 5'(NUM_CLASSES));
  assign dst_ok   = (cls_inc < 5'(NUM_CLASSES));
  assign src_idx  = cls_ok ? cls5[CW-1:0] : '0;
  assign dst_idx  = dst_ok ? cls_inc[CW-1:0] : '0;
  assign src_base = AW'(src_idx) * AW'(WORDS_PER_CLASS);
  assign dst_base = AW'(dst_idx) * AW'(WORDS_PER_CLASS);
  assign end_x    = WX'(c_end);
  assign len_x    = WX'(1) << c_cls;
  assign wpc_x    = WX'(WORDS_PER_CLASS);
  assign f0_x     = WX'(fp[0]);
  assign fn_x     = WX'(fp[dst_idx]);
  assign beg_x    = ((end_x - WX'(1)) >> c_cls) << c_cls;
  assign span_x   = end_x - beg_x;

  always_comb begin
    dec_result  = 1'b0;
    dec_class   = c_cls;
    dec_end     = c_end;
    dec_status  = ST_OK;
    dec_we      = 1'b0;
    dec_waddr   = '0;
    dec_fp0_inc = 1'b0;
    dec_copy    = 1'b0;
    dec_read    = 1'b0;
    dec_src     = '0;
    dec_dst     = '0;
    dec_cnt     = '0;
    case (c_cmd)
      CMD_START: begin
        dec_result = 1'b1;
        dec_class  = 3'd0;
        if (f0_x >= wpc_x) begin
          dec_end    = 11'd0;
          dec_status = ST_REGION;
        end else begin
          dec_we      = 1'b1;
          dec_waddr   = AW'(f0_x);
          dec_fp0_inc = 1'b1;
          dec_end     = 11'(f0_x + WX'(1));
        end
      end
      CMD_APPEND, CMD_GET: begin
        if (!cls_ok) begin
          dec_result = 1'b1;
          dec_status = ST_CLASS;
        end else if (end_x == '0 || end_x > wpc_x) begin
          dec_result = 1'b1;
          dec_status = ST_REGION;
        end else if (c_cmd == CMD_APPEND) begin
          if ((end_x & (len_x - WX'(1))) != '0) begin
            // room left in the slot: write in place
            dec_result = 1'b1;
            if (end_x >= wpc_x) begin
              dec_status = ST_REGION;
            end else begin
              dec_we    = 1'b1;
              dec_waddr = src_base + AW'(end_x);
              dec_end   = 11'(end_x + WX'(1));
            end
          end else if (!dst_ok) begin
            dec_result = 1'b1;
            dec_status = ST_CLASS;
          end else if (fn_x + (len_x << 1) > wpc_x) begin
            dec_result = 1'b1;
            dec_status = ST_REGION;
          end else begin
            // slot full: promote into the next class
            dec_copy = 1'b1;
            dec_src  = src_base + AW'(end_x - len_x);
            dec_dst  = dst_base + AW'(fn_x);
            dec_cnt  = PW'(len_x);
          end
        end else begin
          dec_read = 1'b1;
          dec_src  = src_base + AW'(beg_x);
          dec_cnt  = (span_x > WX'(MAX_OUT)) ? PW'(MAX_OUT) : PW'(span_x);
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Store port control
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = dst_addr;
    mem_wdata = rd_q;
    mem_re    = 1'b0;
    mem_raddr = src_addr;
    case (state)
      S_DECODE: begin
        mem_we    = dec_we;
        mem_waddr = dec_waddr;
        mem_wdata = c_val;
      end
      S_COPY: begin
        mem_re = (cnt != '0);
        if (pend) begin
          mem_we = 1'b1;
        end else if (cnt == '0) begin
          mem_we    = 1'b1;
          mem_wdata = c_val;
        end
      end
      S_READ: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Element store, one write and one read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= 1'b0;
      rv_sel <= 1'b0;
      pend   <= 1'b0;
      cnt    <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        fp[i] <= '0;
      end
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            c_cmd <= cmd_t'(cmd);
            c_cls <= list_class;
            c_end <= list_end;
            c_val <= in_ext[VALUE_WIDTH-1:0];
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          new_class <= dec_class;
          new_end   <= dec_end;
          status    <= dec_status;
          last      <= 1'b1;
          rv_sel    <= 1'b0;
          if (dec_fp0_inc) begin
            fp[0] <= fp[0] + PW'(1);
          end
          src_addr <= dec_src;
          dst_addr <= dec_dst;
          cnt      <= dec_cnt;
          pend     <= 1'b0;
          up_idx   <= dst_idx;
          up_fp    <= PW'(fn_x + (len_x << 1));
          up_class <= cls_inc[2:0];
          up_end   <= 11'(fn_x + len_x + WX'(1));
          if (dec_copy) begin
            state <= S_COPY;
          end else if (dec_read) begin
            state <= S_READ;
          end else begin
            valid <= dec_result;
            state <= S_IDLE;
          end
        end
        S_COPY: begin
          // read word i, write it in the next cycle, then the new value
          if (cnt != '0) begin
            src_addr <= src_addr + AW'(1);
            cnt      <= cnt - PW'(1);
          end
          pend <= (cnt != '0);
          if (pend) begin
            dst_addr <= dst_addr + AW'(1);
          end else if (cnt == '0) begin
            fp[up_idx] <= up_fp;
            valid      <= 1'b1;
            new_class  <= up_class;
            new_end    <= up_end;
            status     <= ST_OK;
            last       <= 1'b1;
            rv_sel     <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_READ: begin
          // one word per cycle, shown as the read data lands
          src_addr  <= src_addr + AW'(1);
          cnt       <= cnt - PW'(1);
          valid     <= 1'b1;
          new_class <= c_cls;
          new_end   <= c_end;
          status    <= ST_OK;
          rv_sel    <= 1'b1;
          last      <= (cnt == PW'(1));
          if (cnt == PW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // copy reads one region and writes another
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("store read and write hit the same entry");

  // a read out streams without gaps until its last word
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |=> valid)
    else $error("read out stream broke before last word");

  // any error result closes its command
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (valid && status != ST_OK) |-> (last && !rv_sel))
    else $error("error result not marked last");

  // class 0 fill pointer stays inside its region
  a_fp0_bound: assert property (@(posedge clk) disable iff (rst)
    WX'(fp[0]) <= wpc_x)
    else $error("class 0 fill pointer overran its region");

endmodule
